@@ hw/rtl/kdlp_pkg.sv @@
// Package for the debounced key with long press and auto-repeat.
// Holds widths, register indexes, event codes and the counter helpers.
// No dependencies; every other file of the block imports it.
package kdlp_pkg;

  // Width of the internal tick counters; each counter saturates at all ones.
  localparam int COUNT_WIDTH = 16;
  // Width of the configuration thresholds.
  localparam int TICK_W = 16;
  // Compare width that holds both a counter and a threshold without loss.
  localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TICK_W-1:0]      tick_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  localparam cfg_idx_t REG_DEBOUNCE = 2'd0;
  localparam cfg_idx_t REG_LONG     = 2'd1;
  localparam cfg_idx_t REG_REPEAT   = 2'd2;

  localparam tick_t DEBOUNCE_RST = 16'd20;
  localparam tick_t LONG_RST     = 16'd500;
  localparam tick_t REPEAT_RST   = 16'd200;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } key_event_t;

  typedef struct packed {
    tick_t debounce_ticks;
    tick_t long_press_ticks;
    tick_t repeat_ticks;
  } cfg_t;

  typedef struct packed {
    key_event_t key_event;
    logic       key_pressed;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
  endfunction

  // True when the counter has reached the threshold.
  function automatic logic reached(input count_t c, input tick_t t);
    logic [CMP_W-1:0] ce;
    logic [CMP_W-1:0] te;
    ce = CMP_W'(c);
    te = CMP_W'(t);
    reached = (ce >= te);
  endfunction

endpackage

@@ hw/rtl/kdlp_if.sv @@
// Channel interfaces of the debounced key block: tick input, result output
// and configuration write. Depends on kdlp_pkg.
interface kdlp_in_if;
  import kdlp_pkg::*;
  logic valid;
  logic ready;
  logic key_level;
  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

interface kdlp_out_if;
  import kdlp_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] key_event;
  logic       key_pressed;
  modport source (output valid, output key_event, output key_pressed, input ready);
  modport sink (input valid, input key_event, input key_pressed, output ready);
endinterface

interface kdlp_cfg_if;
  import kdlp_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  tick_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/kdlp_cfg_regs.sv @@
// Configuration register file of the debounced key block.
// Depends on kdlp_pkg; writes to an unused index are dropped.
module kdlp_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  kdlp_pkg::cfg_idx_t wr_index,
  input  kdlp_pkg::tick_t   wr_data,
  output kdlp_pkg::cfg_t    cfg
);
  import kdlp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.long_press_ticks <= LONG_RST;
      cfg_r.repeat_ticks     <= REPEAT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE: cfg_r.debounce_ticks   <= wr_data;
        REG_LONG:     cfg_r.long_press_ticks <= wr_data;
        REG_REPEAT:   cfg_r.repeat_ticks     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/kdlp_core.sv @@
// Key state and per-tick update logic of the debounced key block.
// Depends on kdlp_pkg; updates its state on every accepted tick.
module kdlp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              key_level,
  input  kdlp_pkg::cfg_t    cfg,
  output kdlp_pkg::result_t result
);
  import kdlp_pkg::*;

  logic   last_level_r, last_level_nxt;
  logic   armed_r, armed_nxt;
  count_t deb_cnt_r, deb_cnt_nxt;
  logic   pressed_r, pressed_nxt;
  logic   long_r, long_nxt;
  count_t hold_cnt_r, hold_cnt_nxt;
  count_t rep_cnt_r, rep_cnt_nxt;
  key_event_t ev;

  always_comb begin
    last_level_nxt = last_level_r;
    armed_nxt      = armed_r;
    deb_cnt_nxt    = deb_cnt_r;
    pressed_nxt    = pressed_r;
    long_nxt       = long_r;
    hold_cnt_nxt   = pressed_r ? sat_inc(hold_cnt_r) : hold_cnt_r;
    rep_cnt_nxt    = pressed_r ? sat_inc(rep_cnt_r) : rep_cnt_r;
    ev             = EV_NONE;

    if (key_level != last_level_r || !armed_r) begin
      // A level change, or the first tick after reset, restarts debouncing.
      last_level_nxt = key_level;
      armed_nxt      = 1'b1;
      deb_cnt_nxt    = '0;
    end else begin
      deb_cnt_nxt = sat_inc(deb_cnt_r);
      if (reached(deb_cnt_nxt, cfg.debounce_ticks)) begin
        if (!key_level) begin
          if (!pressed_r) begin
            pressed_nxt  = 1'b1;
            long_nxt     = 1'b0;
            hold_cnt_nxt = '0;
            rep_cnt_nxt  = '0;
            ev           = EV_SHORT;
          end else if (!long_r && reached(hold_cnt_nxt, cfg.long_press_ticks)) begin
            long_nxt    = 1'b1;
            rep_cnt_nxt = '0;
            ev          = EV_LONG;
          end else if (long_r && reached(rep_cnt_nxt, cfg.repeat_ticks)) begin
            rep_cnt_nxt = '0;
            ev          = EV_REPEAT;
          end
        end else begin
          pressed_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      armed_r      <= 1'b0;
      deb_cnt_r    <= '0;
      pressed_r    <= 1'b0;
      long_r       <= 1'b0;
      hold_cnt_r   <= '0;
      rep_cnt_r    <= '0;
    end else if (step) begin
      last_level_r <= last_level_nxt;
      armed_r      <= armed_nxt;
      deb_cnt_r    <= deb_cnt_nxt;
      pressed_r    <= pressed_nxt;
      long_r       <= long_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      rep_cnt_r    <= rep_cnt_nxt;
    end
  end

  assign result.key_event   = ev;
  assign result.key_pressed = pressed_nxt;

endmodule

@@ hw/rtl/key_debounce_long_press_repeat.sv @@
// Top level of the debounced key with long press and auto-repeat.
// Depends on kdlp_pkg, the interfaces in kdlp_if, kdlp_cfg_regs and kdlp_core.
//
//   Channel  Direction  Payload                        Handshake
//   in_ch    sink       key_level (1 bit)               valid / ready
//   out_ch   source     key_event (2), key_pressed (1)  valid / ready
//   cfg_ch   sink       index (2), data (16)            valid / ready
//
// One tick item is accepted per clock cycle while the output register is not
// stalled; its result appears in the output register on the next cycle, so the
// sustained rate is one item per cycle as long as the receiver takes each result.
// rst_n is synchronous and active low; it clears the key state, empties the
// output register and loads the default thresholds (20, 500, 200 ticks).
// A stalled result blocks new ticks only while it is still unread.
module key_debounce_long_press_repeat (
  input logic     clk,
  input logic     rst_n,
  kdlp_in_if.sink   in_ch,
  kdlp_out_if.source out_ch,
  kdlp_cfg_if.sink  cfg_ch
);
  import kdlp_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    in_fire;

  logic       out_valid_r;
  key_event_t out_event_r;
  logic       out_pressed_r;

  // The configuration port never stalls.
  assign cfg_ch.ready = 1'b1;

  kdlp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // A new tick goes in whenever the output register is empty or is being
  // drained in this same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  kdlp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .key_level (in_ch.key_level),
    .cfg       (cfg),
    .result    (result)
  );

  // Output register: every tick produces exactly one result item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload needs no reset; it loads with each accepted tick.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_event_r   <= result.key_event;
      out_pressed_r <= result.key_pressed;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_event   = out_event_r;
  assign out_ch.key_pressed = out_pressed_r;

endmodule

@@ hw/rtl/kdlp_checker.sv @@
// Port-level checks for the debounced key block, bound to its top level.
// Depends on kdlp_pkg and key_debounce_long_press_repeat.
module kdlp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_key_event,
  input logic       out_key_pressed
);
  import kdlp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_key_event) && $stable(out_key_pressed))
    else $error("stalled result item changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no result item");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_event_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_key_event != EV_NONE |-> out_key_pressed)
    else $error("key event reported while not pressed");

endmodule

bind key_debounce_long_press_repeat kdlp_checker u_kdlp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_key_event   (out_ch.key_event),
  .out_key_pressed (out_ch.key_pressed)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for key_debounce_long_press_repeat. It drives tick items with random
// gaps and result stalls, predicts each result and checks it field by field.
// Depends on kdlp_pkg, the kdlp_if interfaces and the block under test.
module tb_top;
  import kdlp_pkg::*;

  localparam longint LIMIT_CYCLES = 2_000_000;
  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_LEN = 300;
  // Index with no register behind it; the block must ignore writes to it.
  localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(3);
  // Raw pin levels; the key is active low.
  localparam logic LVL_DOWN = 1'b0;
  localparam logic LVL_UP = 1'b1;

  logic clk;
  logic rst_n;

  kdlp_in_if  in_ch ();
  kdlp_out_if out_ch ();
  kdlp_cfg_if cfg_ch ();

  key_debounce_long_press_repeat dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predicted key state and the thresholds it is judged against.
  tick_t  th_debounce;
  tick_t  th_long;
  tick_t  th_repeat;
  logic   st_last_level;
  logic   st_armed;
  logic   st_pressed;
  logic   st_long;
  count_t cnt_debounce;
  count_t cnt_hold;
  count_t cnt_repeat;

  // Results predicted for accepted ticks, oldest first.
  result_t expected_keys[$];
  result_t want_r;

  int     mismatches = 0;
  int     results_seen = 0;
  int     items_sent = 0;
  longint cycles = 0;
  bit     tick_offered = 0;
  bit     gaps_on = 0;
  bit     stalls_on = 0;
  // A long receiver hold-off starts whenever hold_reqs moves past hold_seen.
  int     hold_reqs = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     stall_left = 0;

  // The clock runs at 500 MHz.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit. A hung handshake ends the run here as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("key_debounce_long_press_repeat: mismatch");
      $finish;
    end
  end

  // Most pauses are short; the rest are much longer.
  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic count_t count_up(count_t v);
    return (&v) ? v : v + count_t'(1);
  endfunction

  function automatic bit at_least(count_t c, tick_t t);
    return longint'(c) >= longint'(t);
  endfunction

  task automatic reset_key_state();
    th_debounce = DEBOUNCE_RST;
    th_long = LONG_RST;
    th_repeat = REPEAT_RST;
    st_last_level = 1'b0;
    st_armed = 1'b0;
    st_pressed = 1'b0;
    st_long = 1'b0;
    cnt_debounce = '0;
    cnt_hold = '0;
    cnt_repeat = '0;
  endtask

  // Advances the predicted key state by one tick and returns what the block
  // must report for it. The hold and repeat counts run on every tick while
  // pressed, bounces included, but are only looked at on stable ticks.
  function automatic result_t next_key_result(logic level);
    result_t    r;
    key_event_t ev;
    ev = EV_NONE;
    if (st_pressed) begin
      cnt_hold = count_up(cnt_hold);
      cnt_repeat = count_up(cnt_repeat);
    end
    if (level != st_last_level || !st_armed) begin
      // A level change, or the first tick after reset, restarts the debounce.
      st_last_level = level;
      st_armed = 1'b1;
      cnt_debounce = '0;
    end else begin
      cnt_debounce = count_up(cnt_debounce);
      if (at_least(cnt_debounce, th_debounce)) begin
        if (level == LVL_DOWN) begin
          if (!st_pressed) begin
            st_pressed = 1'b1;
            st_long = 1'b0;
            cnt_hold = '0;
            cnt_repeat = '0;
            ev = EV_SHORT;
          end else if (!st_long && at_least(cnt_hold, th_long)) begin
            st_long = 1'b1;
            cnt_repeat = '0;
            ev = EV_LONG;
          end else if (st_long && at_least(cnt_repeat, th_repeat)) begin
            cnt_repeat = '0;
            ev = EV_REPEAT;
          end
        end else begin
          // A stable release clears the press; the long flag stays until
          // the next press.
          st_pressed = 1'b0;
        end
      end
    end
    r.key_event = ev;
    r.key_pressed = st_pressed;
    return r;
  endfunction

  // Receiver side. It is ready unless a long hold-off or a random stall is
  // running. Stalls only start while stalls_on is set.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN - 1;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(99) < 20) begin
        stall_left = pause_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker. Every accepted result is compared with the oldest
  // prediction; a result with nothing predicted is a failure too.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_keys.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: event %0d pressed %0b",
                   out_ch.key_event, out_ch.key_pressed);
        mismatches++;
      end else begin
        want_r = expected_keys.pop_front();
        if (out_ch.key_event !== want_r.key_event ||
            out_ch.key_pressed !== want_r.key_pressed) begin
          if (mismatches < 10)
            $display("result %0d: expected event %s pressed %0b, got event %0d pressed %0b",
                     results_seen, want_r.key_event.name(), want_r.key_pressed,
                     out_ch.key_event, out_ch.key_pressed);
          mismatches++;
        end
        results_seen++;
      end
    end
  end

  // Offers one tick item and waits until the block takes it. The valid line
  // stays high into the next item unless a gap is drawn.
  task automatic send_tick(logic level);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.key_level <= level;
    tick_offered = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    expected_keys.push_back(next_key_result(level));
    items_sent++;
    gap = 0;
    if (gaps_on && $urandom_range(99) >= 55) gap = pause_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      tick_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(logic level, int n);
    repeat (n) send_tick(level);
  endtask

  task automatic stop_ticks();
    if (tick_offered) begin
      in_ch.valid <= 1'b0;
      tick_offered = 1'b0;
    end
  endtask

  // Stops offering ticks and waits for every predicted result, then lets the
  // output register settle.
  task automatic drain_results();
    stop_ticks();
    while (expected_keys.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Threshold writes only happen with the block drained.
  task automatic write_reg(cfg_idx_t idx, tick_t value);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE: th_debounce = value;
      REG_LONG:     th_long = value;
      REG_REPEAT:   th_repeat = value;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(tick_t deb, tick_t lng, tick_t rpt);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG, lng);
    write_reg(REG_REPEAT, rpt);
  endtask

  // Out of reset the thresholds are 20, 500 and 200. A press held 23 ticks
  // gives its short event on the 21st, after 20 unstable ticks.
  task automatic test_reset_thresholds();
    send_run(LVL_DOWN, 23);
    send_run(LVL_UP, 22);
  endtask

  // With every threshold at zero the first tick after a restart is stable,
  // the long event follows the short one at once and repeats come on every
  // stable pressed tick. A bounce in the middle must not lose the press.
  task automatic test_zero_thresholds();
    set_thresholds('0, '0, '0);
    // This write must be ignored; all thresholds stay at zero.
    write_reg(REG_UNUSED, tick_t'(7));
    send_run(LVL_UP, 2);
    send_run(LVL_DOWN, 5);
    send_run(LVL_UP, 1);
    send_run(LVL_DOWN, 2);
    send_run(LVL_UP, 2);
  endtask

  // Largest debounce time: a short press is never seen. Then the smallest
  // nonzero settings, where every event comes as early as with zero thresholds.
  task automatic test_threshold_edges();
    set_thresholds(16'hFFFF, tick_t'(1), tick_t'(1));
    send_run(LVL_DOWN, 6);
    send_run(LVL_UP, 2);
    write_reg(REG_DEBOUNCE, tick_t'(1));
    send_run(LVL_DOWN, 8);
    send_run(LVL_UP, 3);
  endtask

  // Largest long-press and repeat times. A hold of a few hundred ticks stays
  // far below them, so only the short event comes.
  task automatic test_longest_hold();
    gaps_on = 0;
    stalls_on = 0;
    set_thresholds('0, 16'hFFFF, 16'hFFFF);
    send_run(LVL_UP, 2);
    send_run(LVL_DOWN, 300);
    send_run(LVL_UP, 3);
  endtask

  // Up to four bounces shorter than the debounce time, alternating levels.
  task automatic send_bounce();
    int n;
    int lim;
    logic lvl;
    n = $urandom_range(4);
    lim = (th_debounce > 1) ? int'(th_debounce) : 1;
    lvl = 1'($urandom_range(1));
    repeat (n) begin
      send_run(lvl, $urandom_range(lim, 1));
      lvl = ~lvl;
    end
  endtask

  // A stable run, usually long enough to pass the debounce and often long
  // enough to bring the long event and a few repeats.
  task automatic send_stable(logic level);
    int span;
    span = int'(th_debounce) + int'(th_long) + 3 * int'(th_repeat) + 3;
    if ($urandom_range(99) < 70)
      send_run(level, $urandom_range(span, int'(th_debounce) + 1));
    else
      send_run(level, $urandom_range(span));
  endtask

  // Mostly full press and release sequences with bounces in front of each
  // edge; the rest is random pin noise.
  task automatic send_key_sequence();
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(12, 1)) send_tick(1'($urandom_range(1)));
    end else begin
      send_bounce();
      send_stable(LVL_DOWN);
      send_bounce();
      send_stable(LVL_UP);
    end
  endtask

  // Random phases under changing thresholds. Every third phase runs with no
  // gaps and no stalls.
  task automatic test_random_presses();
    int phase;
    int target;
    phase = 0;
    target = items_sent;
    while (items_sent - target < RANDOM_ITEMS) begin
      drain_results();
      gaps_on = (phase % 3 != 0);
      stalls_on = (phase % 3 != 0);
      case (phase % 4)
        0: set_thresholds(tick_t'(1), tick_t'(1), tick_t'(1));
        1: set_thresholds('0, tick_t'($urandom_range(30)), '0);
        default: set_thresholds(tick_t'($urandom_range(12)), tick_t'($urandom_range(40)),
                                tick_t'($urandom_range(15)));
      endcase
      repeat (4) send_key_sequence();
      phase++;
    end
  endtask

  // The receiver holds off for a long stretch while ticks keep coming, so
  // the block fills and stalls its input. Then the sender waits for every
  // result before going on.
  task automatic test_backpressure();
    gaps_on = 0;
    stalls_on = 0;
    set_thresholds(tick_t'(2), tick_t'(5), tick_t'(2));
    hold_reqs <= hold_reqs + 1;
    send_run(LVL_DOWN, 30);
    send_run(LVL_UP, 10);
    drain_results();
    stalls_on = 1;
    gaps_on = 1;
    send_run(LVL_DOWN, 20);
    send_run(LVL_UP, 6);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.key_level <= LVL_UP;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_DEBOUNCE;
    cfg_ch.data <= '0;
    reset_key_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_thresholds();
    test_zero_thresholds();
    test_threshold_edges();
    test_random_presses();
    test_backpressure();
    test_longest_hold();

    drain_results();
    repeat (4) @(posedge clk);
    if (expected_keys.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("key_debounce_long_press_repeat: match");
    end else begin
      $display("key_debounce_long_press_repeat: mismatch");
    end
    $finish;
  end

endmodule
